// ----- rtl/ising_metropolis_lattice_assert.svh -----
// Assertion macros shared by the lattice modules.
`ifndef ISING_METROPOLIS_LATTICE_ASSERT_SVH
`define ISING_METROPOLIS_LATTICE_ASSERT_SVH

// Same-cycle implication, held off during reset.
`define IML_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, held off during reset.
`define IML_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// ----- rtl/iml_pkg.sv -----
`default_nettype none
package iml_pkg;
  localparam int ROW_BITS     = 6;
  localparam int SIDE         = 1 << ROW_BITS;
  localparam int FIELD_BITS   = 6;
  localparam int RNG_BITS     = 15;
  localparam int ACC_BITS     = 16;
  localparam int HALF_BITS    = 17;
  localparam int THR_BITS     = 2 * HALF_BITS;
  localparam int NUM_REGS     = 5;
  localparam int REG_IDX_BITS = 3;
  localparam int NET_BITS     = 14;
  localparam int CHG_BITS     = 3;

  localparam logic [THR_BITS-1:0] THR_RESET = 34'd8590000128;
  localparam logic signed [NET_BITS-1:0] NET_RESET = NET_BITS'(SIDE * SIDE);
  localparam logic signed [CHG_BITS-1:0] CHG_UP   = 3'sd2;
  localparam logic signed [CHG_BITS-1:0] CHG_DOWN = -3'sd2;
  localparam logic signed [CHG_BITS-1:0] CHG_NONE = 3'sd0;

  // Action codes; the unused codes behave as a read.
  localparam logic [1:0] ACT_WRITE = 2'd0;
  localparam logic [1:0] ACT_TRIAL = 2'd2;

  typedef struct packed {
    logic                load;
    logic                rd_own;
    logic                rd_dn;
    logic                eval;
    logic                clr_we;
    logic [ROW_BITS-1:0] clr_row;
  } iml_cmd_t;
endpackage
`default_nettype wire

// ----- rtl/ising_metropolis_lattice.sv -----
// A request taken in idle runs the own-row read, lower-row read and evaluate states; done is
//   registered on leaving evaluate. busy holds off new requests until then; the single lattice
//   row memory is used in turn (own and upper row, lower row, then evaluate and write back).
// Reset: synchronous, active high; afterwards a clearing pass sets every row to +1 spins,
//   with busy high; thresholds and net spin reset at once. The receiver cannot stall.
`default_nettype none
module ising_metropolis_lattice
  import iml_pkg::*;
(
  input  wire logic                        clk,
  input  wire logic                        rst,
  // request channel
  input  wire logic                        start,
  output      logic                        busy,
  input  wire logic [1:0]                  action,
  input  wire logic [FIELD_BITS-1:0]       row,
  input  wire logic [FIELD_BITS-1:0]       col,
  input  wire logic                        spin_value,
  input  wire logic [RNG_BITS-1:0]         row_random,
  input  wire logic [RNG_BITS-1:0]         col_random,
  input  wire logic [ACC_BITS-1:0]         accept_random,
  // result channel
  output      logic                        done,
  output      logic [FIELD_BITS-1:0]       site_row,
  output      logic [FIELD_BITS-1:0]       site_col,
  output      logic                        site_spin,
  output      logic                        flipped,
  output      logic signed [CHG_BITS-1:0]  spin_change,
  output      logic signed [NET_BITS-1:0]  net_spin,
  // threshold register writes
  input  wire logic                        cfg_valid,
  output      logic                        cfg_ready,
  input  wire logic [REG_IDX_BITS-1:0]     cfg_index,
  input  wire logic [THR_BITS-1:0]         cfg_data
);
  // The lattice is stored one row per memory word, so a trial reads the
  // own row (both side neighbours come from it), the upper row and the
  // lower row, then writes the own row back when the flip is accepted.
  // Row and column arithmetic wraps naturally at the row width, which
  // gives the periodic boundary in both directions.

  iml_cmd_t cmd;

  // Registers are always writable; the user must issue writes only while idle, the block does not enforce it.
  assign cfg_ready = 1'b1;

  iml_ctrl u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .busy  (busy),
    .done  (done),
    .cmd   (cmd)
  );

  iml_datapath u_dp (
    .clk           (clk),
    .rst           (rst),
    .cmd           (cmd),
    .cfg_we        (cfg_valid && cfg_ready),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .action        (action),
    .row           (row),
    .col           (col),
    .spin_value    (spin_value),
    .row_random    (row_random),
    .col_random    (col_random),
    .accept_random (accept_random),
    .site_row      (site_row),
    .site_col      (site_col),
    .site_spin     (site_spin),
    .flipped       (flipped),
    .spin_change   (spin_change),
    .net_spin      (net_spin)
  );
endmodule
`default_nettype wire

// ----- rtl/iml_lattice_ram.sv -----
`default_nettype none
module iml_lattice_ram #(
  parameter int ADDR_BITS = 6,
  parameter int DATA_BITS = 64
) (
  input  wire logic                 clk,
  input  wire logic                 we,
  input  wire logic [ADDR_BITS-1:0] waddr,
  input  wire logic [DATA_BITS-1:0] wdata,
  input  wire logic                 re_a,
  input  wire logic [ADDR_BITS-1:0] raddr_a,
  output      logic [DATA_BITS-1:0] rdata_a,
  input  wire logic                 re_b,
  input  wire logic [ADDR_BITS-1:0] raddr_b,
  output      logic [DATA_BITS-1:0] rdata_b
);
  logic [DATA_BITS-1:0] mem [1 << ADDR_BITS];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re_a) begin
      rdata_a <= mem[raddr_a];
    end
    if (re_b) begin
      rdata_b <= mem[raddr_b];
    end
  end
endmodule
`default_nettype wire

// ----- rtl/iml_ctrl.sv -----
`default_nettype none
module iml_ctrl
  import iml_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic start,
  output      logic busy,
  output      logic done,
  output      iml_cmd_t cmd
);
`include "ising_metropolis_lattice_assert.svh"

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_RD_OWN,
    S_RD_DN,
    S_EVAL
  } state_t;

  state_t              state;
  logic [ROW_BITS-1:0] clr_row;

  assign busy = (state != S_IDLE);

  always_comb begin
    cmd         = '0;
    cmd.load    = start && (state == S_IDLE);
    cmd.rd_own  = (state == S_RD_OWN);
    cmd.rd_dn   = (state == S_RD_DN);
    cmd.eval    = (state == S_EVAL);
    cmd.clr_we  = (state == S_CLEAR);
    cmd.clr_row = clr_row;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= S_CLEAR;
      clr_row <= '0;
      done    <= 1'b0;
    end else begin
      done <= 1'b0;
      unique case (state)
        S_CLEAR: begin
          clr_row <= clr_row + ROW_BITS'(1);
          if (clr_row == ROW_BITS'(SIDE - 1)) begin
            state <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (start) begin
            state <= S_RD_OWN;
          end
        end
        S_RD_OWN: state <= S_RD_DN;
        S_RD_DN:  state <= S_EVAL;
        S_EVAL: begin
          done  <= 1'b1;
          state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  `IML_ASSERT_NEXT(a_done_single, done, !done, "result strobe held longer than one cycle")
  `IML_ASSERT_NOW(a_done_idle, done, !busy, "result strobe while busy")
  `IML_ASSERT_NEXT(a_accept_busy, start && !busy, busy && !done, "request not taken up")
endmodule
`default_nettype wire

// ----- rtl/iml_datapath.sv -----
`default_nettype none
module iml_datapath
  import iml_pkg::*;
(
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire iml_cmd_t                    cmd,
  input  wire logic                        cfg_we,
  input  wire logic [REG_IDX_BITS-1:0]     cfg_index,
  input  wire logic [THR_BITS-1:0]         cfg_data,
  input  wire logic [1:0]                  action,
  input  wire logic [FIELD_BITS-1:0]       row,
  input  wire logic [FIELD_BITS-1:0]       col,
  input  wire logic                        spin_value,
  input  wire logic [RNG_BITS-1:0]         row_random,
  input  wire logic [RNG_BITS-1:0]         col_random,
  input  wire logic [ACC_BITS-1:0]         accept_random,
  output      logic [FIELD_BITS-1:0]       site_row,
  output      logic [FIELD_BITS-1:0]       site_col,
  output      logic                        site_spin,
  output      logic                        flipped,
  output      logic signed [CHG_BITS-1:0]  spin_change,
  output      logic signed [NET_BITS-1:0]  net_spin
);
`include "ising_metropolis_lattice_assert.svh"

  logic [THR_BITS-1:0]  thr [NUM_REGS];
  logic [1:0]           act;
  logic [ROW_BITS-1:0]  r_q;
  logic [ROW_BITS-1:0]  c_q;
  logic                 spin_q;
  logic [ACC_BITS-1:0]  acc_q;
  logic                 up_bit;

  logic [SIDE-1:0]      row_own;
  logic [SIDE-1:0]      row_b;
  logic [SIDE-1:0]      row_new;
  logic [ROW_BITS-1:0]  lf_col;
  logic [ROW_BITS-1:0]  rt_col;
  logic [2:0]           count;
  logic                 old_spin;
  logic                 new_spin;
  logic [HALF_BITS-1:0] thr_sel;
  logic                 accept;
  logic                 is_write;
  logic                 is_trial;
  logic                 ram_we;
  logic [ROW_BITS-1:0]  ram_waddr;
  logic [SIDE-1:0]      ram_wdata;
  logic signed [CHG_BITS-1:0] chg;

  // Threshold registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < NUM_REGS; i++) begin
        thr[i] <= THR_RESET;
      end
    end else if (cfg_we && (cfg_index < REG_IDX_BITS'(NUM_REGS))) begin
      thr[cfg_index] <= cfg_data;
    end
  end

  // Latch the request; trials take the site from the top random bits.
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      act    <= action;
      spin_q <= spin_value;
      acc_q  <= accept_random;
      if (action == ACT_TRIAL) begin
        r_q <= row_random[RNG_BITS-1 -: ROW_BITS];
        c_q <= col_random[RNG_BITS-1 -: ROW_BITS];
      end else begin
        r_q <= row[ROW_BITS-1:0];
        c_q <= col[ROW_BITS-1:0];
      end
    end
    if (cmd.rd_dn) begin
      up_bit <= row_b[c_q];
    end
  end

  assign is_write = (act == ACT_WRITE);
  assign is_trial = (act == ACT_TRIAL);
  assign lf_col   = c_q - ROW_BITS'(1);
  assign rt_col   = c_q + ROW_BITS'(1);
  assign old_spin = row_own[c_q];
  assign count    = 3'(up_bit) + 3'(row_b[c_q]) + 3'(row_own[lf_col]) + 3'(row_own[rt_col]);
  assign thr_sel  = old_spin ? thr[count][THR_BITS-1:HALF_BITS] : thr[count][HALF_BITS-1:0];
  assign accept   = ({1'b0, acc_q} < thr_sel);

  always_comb begin
    new_spin = old_spin;
    if (is_write) begin
      new_spin = spin_q;
    end else if (is_trial && accept) begin
      new_spin = !old_spin;
    end
    chg = CHG_NONE;
    if (new_spin != old_spin) begin
      chg = new_spin ? CHG_UP : CHG_DOWN;
    end
    row_new      = row_own;
    row_new[c_q] = new_spin;
  end

  always_comb begin
    if (cmd.clr_we) begin
      ram_we    = 1'b1;
      ram_waddr = cmd.clr_row;
      ram_wdata = '1;
    end else begin
      ram_we    = cmd.eval && (is_write || (is_trial && accept));
      ram_waddr = r_q;
      ram_wdata = row_new;
    end
  end

  iml_lattice_ram #(
    .ADDR_BITS (ROW_BITS),
    .DATA_BITS (SIDE)
  ) u_ram (
    .clk     (clk),
    .we      (ram_we),
    .waddr   (ram_waddr),
    .wdata   (ram_wdata),
    .re_a    (cmd.rd_own),
    .raddr_a (r_q),
    .rdata_a (row_own),
    .re_b    (cmd.rd_own || cmd.rd_dn),
    .raddr_b (cmd.rd_own ? r_q - ROW_BITS'(1) : r_q + ROW_BITS'(1)),
    .rdata_b (row_b)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      net_spin <= NET_RESET;
      flipped  <= 1'b0;
      spin_change <= CHG_NONE;
    end else if (cmd.eval) begin
      net_spin    <= net_spin + NET_BITS'(chg);
      flipped     <= is_trial && (new_spin != old_spin);
      spin_change <= chg;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.eval) begin
      site_row  <= FIELD_BITS'(r_q);
      site_col  <= FIELD_BITS'(c_q);
      site_spin <= new_spin;
    end
  end

  `IML_ASSERT_NOW(a_flip_moves_net, flipped, spin_change != CHG_NONE, "flip without net change")
  `IML_ASSERT_NEXT(a_net_hold, !cmd.eval, $stable(net_spin), "net spin moved outside evaluation")
  `IML_ASSERT_NOW(a_no_write_on_load, cmd.load, !ram_we || cmd.clr_we, "lattice write at request")
endmodule
`default_nettype wire
